### src/msha_pkg.sv
// ----------------------------------------------------------------------------
// msha_pkg
// Shared codes, field widths and controller/datapath interface structs for
// the mark/sweep handle allocator.
// ----------------------------------------------------------------------------
package msha_pkg;

    localparam int MODE_W    = 3;
    localparam int LEVEL_W   = 5;
    localparam int HANDLE_W  = 10;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MARK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REUSE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWEEP  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNMARK = 3'd4;
    localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic accept;
        logic exec;
        logic al_ev;
        logic w_rd;
        logic w_ev;
        logic clr;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic              lvl_ok;
        logic [MODE_W-1:0] mode;
        logic              alloc_rd;
        logic              walk_go;
        logic              walk_more;
        logic              clr_more;
        logic              out_free;
    } sts_t;

endpackage

### src/msha_datapath.sv
// ----------------------------------------------------------------------------
// msha_datapath
// Per-level allocator registers, mark and link memories, walk counters and
// the output word register.
// ----------------------------------------------------------------------------
module msha_datapath #(
    parameter int CAPACITY = 1024,
    parameter int LEVELS   = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  msha_pkg::cmd_t                 cmd,
    output msha_pkg::sts_t                 sts,
    input  logic [msha_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [msha_pkg::M_TDATA_W-1:0] m_tdata
);
    import msha_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int IW    = $clog2(CAPACITY);
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int DEPTH = LEVELS * CAPACITY;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = (CW > HANDLE_W) ? CW : HANDLE_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    // input unpack
    logic [MODE_W-1:0]   in_mode;
    logic [LEVEL_W-1:0]  in_level;
    logic [HANDLE_W-1:0] in_handle;
    logic [8:0]          in_lv_wide;
    logic                in_lvl_ok;

    assign in_mode    = s_tdata[2:0];
    assign in_level   = s_tdata[7:3];
    assign in_handle  = s_tdata[17:8];
    assign in_lv_wide = 9'(in_level) - 9'd1;
    assign in_lvl_ok  = (in_level != '0) && (9'(in_level) <= 9'(LEVELS));

    logic [MODE_W-1:0] mode_reg;
    logic              lvl_ok_reg;
    logic [LW-1:0]     lv_reg;
    logic [XW-1:0]     h_reg;
    logic [AW-1:0]     base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg   <= in_mode;
            lvl_ok_reg <= in_lvl_ok;
            lv_reg     <= in_lv_wide[LW-1:0];
            h_reg      <= XW'(in_handle);
            base_reg   <= AW'(in_lv_wide[LW-1:0]) * AW'(CAPACITY);
        end
    end

    // per-level state
    logic [CW-1:0] fu_reg    [LEVELS];
    logic [CW-1:0] fc_reg    [LEVELS];
    logic [IW-1:0] head_reg  [LEVELS];
    logic [IW-1:0] reuse_reg [LEVELS];
    logic [IW-1:0] peak_reg  [LEVELS];

    logic [CW-1:0] top_cur, fc_cur;
    logic [IW-1:0] head_cur, reuse_cur, peak_cur;
    logic          h_ge_top;

    assign top_cur   = fu_reg[lv_reg];
    assign fc_cur    = fc_reg[lv_reg];
    assign head_cur  = head_reg[lv_reg];
    assign reuse_cur = reuse_reg[lv_reg];
    assign peak_cur  = peak_reg[lv_reg];
    assign h_ge_top  = h_reg >= XW'(top_cur);

    // walk registers
    logic [CW-1:0] ptr_reg, wtop_reg, wfc_reg, cnt_reg;
    logic [IW-1:0] whead_reg, res_reg;
    logic          trim_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [CW-1:0] j;

    assign j = ptr_reg - CW'(1);

    // memories
    logic          mark_mem [DEPTH];
    logic [IW-1:0] link_mem [DEPTH];
    logic          mark_rd_reg;
    logic [IW-1:0] link_rd_reg;

    logic [IW-1:0] mem_idx;
    logic [AW-1:0] addr;
    logic          mark_we, mark_wd, link_we;
    logic [IW-1:0] link_wd;

    always_comb
    begin
        mem_idx = head_cur;
        mark_we = 1'b0;
        mark_wd = 1'b0;
        link_we = 1'b0;
        link_wd = whead_reg;
        if (cmd.exec && lvl_ok_reg)
        begin
            unique case (mode_reg)
                MODE_ALLOC:
                begin
                    if (reuse_cur != '0)
                    begin
                        mem_idx = reuse_cur;
                        mark_we = 1'b1;
                    end
                    else if (fc_cur != '0 && head_cur != '0)
                    begin
                        mem_idx = head_cur;   // also reads the link of the head
                        mark_we = 1'b1;
                    end
                    else if (fc_cur != '0 && top_cur < CAP_C)
                    begin
                        mem_idx = top_cur[IW-1:0];
                        mark_we = 1'b1;
                    end
                end
                MODE_MARK:
                begin
                    mem_idx = h_reg[IW-1:0];
                    mark_we = !h_ge_top;
                    mark_wd = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.w_rd)
            mem_idx = j[IW-1:0];
        if (cmd.w_ev)
        begin
            mem_idx = j[IW-1:0];
            if (mode_reg == MODE_SWEEP && !(trim_reg && !mark_rd_reg))
            begin
                mark_we = mark_rd_reg;
                link_we = !mark_rd_reg;
            end
        end
        if (cmd.clr)
        begin
            mem_idx = ptr_reg[IW-1:0];
            mark_we = 1'b1;
        end
    end

    assign addr = base_reg + AW'(mem_idx);

    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[addr] <= mark_wd;
        mark_rd_reg <= mark_mem[addr];
        if (link_we)
            link_mem[addr] <= link_wd;
        link_rd_reg <= link_mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LEVELS; i++)
            begin
                fu_reg[i]    <= CW'(1);
                fc_reg[i]    <= CAP_C - CW'(1);
                head_reg[i]  <= '0;
                reuse_reg[i] <= '0;
                peak_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.exec && lvl_ok_reg)
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    if (reuse_cur != '0)
                        reuse_reg[lv_reg] <= '0;
                    else if (fc_cur != '0 && head_cur != '0)
                        fc_reg[lv_reg] <= fc_cur - CW'(1);
                    else if (fc_cur != '0 && top_cur < CAP_C)
                    begin
                        fc_reg[lv_reg] <= fc_cur - CW'(1);
                        fu_reg[lv_reg] <= top_cur + CW'(1);
                        if (top_cur[IW-1:0] > peak_cur)
                            peak_reg[lv_reg] <= top_cur[IW-1:0];
                    end
                end
                else if (mode_reg == MODE_REUSE && !h_ge_top)
                    reuse_reg[lv_reg] <= h_reg[IW-1:0];
            end
            if (cmd.al_ev)
                head_reg[lv_reg] <= link_rd_reg;
            if (cmd.load && lvl_ok_reg && mode_reg == MODE_SWEEP)
            begin
                fu_reg[lv_reg]   <= wtop_reg;
                fc_reg[lv_reg]   <= wfc_reg;
                head_reg[lv_reg] <= whead_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_reg   <= '0;
            cnt_reg   <= '0;
            st_reg    <= ST_OK;
            ptr_reg   <= (mode_reg == MODE_UNMARK) ? CW'(1) : top_cur;
            wtop_reg  <= top_cur;
            wfc_reg   <= CAP_C - top_cur;
            whead_reg <= '0;
            trim_reg  <= 1'b1;
            if (lvl_ok_reg)
            begin
                unique case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (reuse_cur != '0)
                            res_reg <= reuse_cur;
                        else if (fc_cur == '0)
                            st_reg <= ST_FULL;
                        else if (head_cur != '0)
                            res_reg <= head_cur;
                        else if (top_cur >= CAP_C)
                            st_reg <= ST_FULL;
                        else
                            res_reg <= top_cur[IW-1:0];
                    end
                    MODE_MARK, MODE_REUSE, MODE_CHECK:
                    begin
                        if (h_ge_top)
                            st_reg <= ST_RANGE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        if (cmd.w_ev)
        begin
            ptr_reg <= j;
            if (mode_reg == MODE_SWEEP)
            begin
                if (trim_reg && !mark_rd_reg)
                begin
                    // unmarked slot at the top: drop it from the used range
                    wtop_reg <= j;
                    wfc_reg  <= wfc_reg + CW'(1);
                end
                else
                begin
                    trim_reg <= 1'b0;
                    if (!mark_rd_reg)
                    begin
                        whead_reg <= j[IW-1:0];
                        wfc_reg   <= wfc_reg + CW'(1);
                    end
                end
            end
            else if (mark_rd_reg)
                cnt_reg <= cnt_reg + CW'(1);
        end
        if (cmd.clr)
            ptr_reg <= ptr_reg + CW'(1);
    end

    // output word
    logic                out_valid_reg;
    logic [HANDLE_W-1:0] o_res_reg, o_cnt_reg, o_peak_reg;
    logic [STATUS_W-1:0] o_st_reg;
    logic [XW-1:0]       res_x, cnt_x, peak_x;

    // status to controller
    assign sts.lvl_ok    = lvl_ok_reg;
    assign sts.mode      = mode_reg;
    assign sts.alloc_rd  = (reuse_cur == '0) && (fc_cur != '0) && (head_cur != '0);
    assign sts.walk_go   = top_cur > CW'(1);
    assign sts.walk_more = ptr_reg > CW'(2);
    assign sts.clr_more  = ({1'b0, ptr_reg} + (CW+1)'(1)) < {1'b0, top_cur};
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign res_x  = XW'(res_reg);
    assign cnt_x  = (mode_reg == MODE_SWEEP && lvl_ok_reg) ? XW'(wfc_reg) : XW'(cnt_reg);
    assign peak_x = lvl_ok_reg ? XW'(peak_cur) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            o_res_reg  <= res_x[HANDLE_W-1:0];
            o_cnt_reg  <= cnt_x[HANDLE_W-1:0];
            o_peak_reg <= peak_x[HANDLE_W-1:0];
            o_st_reg   <= st_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {o_st_reg, o_peak_reg, o_cnt_reg, o_res_reg};

    // a walk never looks at the reserved slot
    a_walk_above_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.w_ev |-> ptr_reg >= CW'(2))
        else $error("walk reached reserved slot");

    a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && lvl_ok_reg) |-> fc_cur < CAP_C)
        else $error("free count above capacity");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("loaded word not presented");

endmodule

### src/msha_ctrl.sv
// ----------------------------------------------------------------------------
// msha_ctrl
// Sequencer: accepts one word, runs its operation over the datapath and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module msha_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  msha_pkg::sts_t sts,
    output msha_pkg::cmd_t cmd
);
    import msha_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_ALEV = 7'b0000100,
        S_WRD  = 7'b0001000,
        S_WEV  = 7'b0010000,
        S_CLR  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_tready   = (state_reg == S_IDLE);
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.al_ev  = (state_reg == S_ALEV);
    assign cmd.w_rd   = (state_reg == S_WRD);
    assign cmd.w_ev   = (state_reg == S_WEV);
    assign cmd.clr    = (state_reg == S_CLR);
    assign cmd.load   = (state_reg == S_OUT) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_OUT;
                if (sts.lvl_ok)
                begin
                    if (sts.mode == MODE_ALLOC && sts.alloc_rd)
                        state_next = S_ALEV;
                    else if ((sts.mode == MODE_SWEEP || sts.mode == MODE_COUNT)
                             && sts.walk_go)
                        state_next = S_WRD;
                    else if (sts.mode == MODE_UNMARK && sts.walk_go)
                        state_next = S_CLR;
                end
            end
            S_ALEV:
                state_next = S_OUT;
            S_WRD:
                state_next = S_WEV;
            S_WEV:
                state_next = sts.walk_more ? S_WRD : S_OUT;
            S_CLR:
                state_next = sts.clr_more ? S_CLR : S_OUT;
            S_OUT:
                if (sts.out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> state_reg == S_EXEC)
        else $error("accepted word not executed");

endmodule

### src/mark_sweep_handle_allocator.sv
// ----------------------------------------------------------------------------
// mark_sweep_handle_allocator
// Per-level slot handle allocator with reuse slot, free list and mark/sweep.
// ----------------------------------------------------------------------------
// One word in, one word out. Each word is accepted in the idle state, run
// in the exec state and loaded into the output register in the out state.
// Allocate with the reuse slot or a never-used slot, mark, reuse and check
// go straight from exec to out; allocate from the free list adds the alev
// state (one extra link-memory read). Count and sweep walk the level's used
// slots downward through the single mark-memory port, with a read state and
// an evaluate state per slot visited. Unmark-all clears one slot per cycle.
// The next word is taken once the result sits in the output register; a
// result held by m_tready low can stall the input. The mark and link
// memories need no clearing after reset.
module mark_sweep_handle_allocator #(
    parameter int CAPACITY = 1024,
    parameter int LEVELS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // mode[2:0], level[7:3], handle[17:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // result_handle[9:0], count[19:10],
                                   // peak_handle[29:20], status[31:30]
);
    import msha_pkg::*;

    cmd_t cmd;
    sts_t sts;

    msha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msha_datapath #(
        .CAPACITY (CAPACITY),
        .LEVELS   (LEVELS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### tb/mark_sweep_handle_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mark_sweep_handle_allocator_tb
// A table of directed words runs first, then random traffic in several
// idle/stall phases, then a short burst on one level after a full drain.
// Every result word is checked field by field, against the table's values where
// a row gives them, else a behavioral model of the per-level stores in the bench.
// ----------------------------------------------------------------------------
module mark_sweep_handle_allocator_tb;
    import msha_pkg::*;

    localparam int CAP        = 1024;
    localparam int NLEV       = 16;
    localparam int WDOG_LIMIT = 40000;
    localparam int NRAND      = 720;
    localparam logic [2:0] MODE_NONE = 3'd7;

    typedef struct {
        logic [9:0] res;
        logic [9:0] cnt;
        logic [9:0] pk;
        logic [1:0] st;
    } alloc_result_t;

    typedef struct {
        logic [2:0] mode;
        logic [4:0] level;
        logic [9:0] handle;
        bit         known;
        logic [9:0] res;
        logic [9:0] cnt;
        logic [9:0] pk;
        logic [1:0] st;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    // model state
    int unsigned   first_unused[NLEV];
    int unsigned   free_head[NLEV];
    int unsigned   free_count[NLEV];
    int unsigned   reuse_slot[NLEV];
    int unsigned   peak[NLEV];
    bit            mark_bits[NLEV][CAP];
    int unsigned   next_link[NLEV][CAP];

    alloc_result_t pending[$];
    int            errors = 0;
    int            idle_pct;
    int            stall_pct;
    int            quiet_cycles = 0;

    mark_sweep_handle_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic alloc_result_t apply_op(logic [2:0] mode, logic [4:0] level,
                                               logic [9:0] h);
        alloc_result_t r;
        int unsigned lv;
        int unsigned top;
        r = '{res: '0, cnt: '0, pk: '0, st: ST_OK};
        if (level < 1 || level > NLEV)
            return r;
        lv  = level - 1;
        top = first_unused[lv];
        case (mode)
            MODE_ALLOC:
                if (reuse_slot[lv] != 0)
                begin
                    r.res = 10'(reuse_slot[lv]);
                    reuse_slot[lv] = 0;
                    mark_bits[lv][r.res] = 0;
                end
                else if (free_count[lv] == 0)
                    r.st = ST_FULL;
                else if (free_head[lv] != 0)
                begin
                    r.res = 10'(free_head[lv]);
                    free_count[lv]--;
                    free_head[lv] = next_link[lv][r.res];
                    mark_bits[lv][r.res] = 0;
                end
                else if (top >= CAP)
                    r.st = ST_FULL;
                else
                begin
                    r.res = 10'(top);
                    free_count[lv]--;
                    mark_bits[lv][top] = 0;
                    if (top > peak[lv]) peak[lv] = top;
                    first_unused[lv] = top + 1;
                end
            MODE_MARK:
                if (h >= top) r.st = ST_RANGE;
                else mark_bits[lv][h] = 1;
            MODE_REUSE:
                if (h >= top) r.st = ST_RANGE;
                else reuse_slot[lv] = 32'(h);
            MODE_SWEEP:
            begin
                while (top > 1 && !mark_bits[lv][top-1]) top--;
                first_unused[lv] = top;
                free_count[lv]   = CAP - top;
                free_head[lv]    = 0;
                for (int i = top - 1; i >= 1; i--)
                    if (mark_bits[lv][i])
                        mark_bits[lv][i] = 0;
                    else
                    begin
                        next_link[lv][i] = free_head[lv];
                        free_head[lv] = i;
                        free_count[lv]++;
                    end
                r.cnt = 10'(free_count[lv]);
            end
            MODE_UNMARK:
                for (int i = 1; i < top; i++) mark_bits[lv][i] = 0;
            MODE_COUNT:
                for (int i = 1; i < top; i++) r.cnt = r.cnt + 10'(mark_bits[lv][i]);
            MODE_CHECK:
                if (h >= top) r.st = ST_RANGE;
            default: ;
        endcase
        r.pk = 10'(peak[lv]);
        return r;
    endfunction

    // drive one word, apply it to the model once accepted
    task automatic send_word(logic [2:0] mode, logic [4:0] level, logic [9:0] h,
                             bit known, alloc_result_t typed);
        alloc_result_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, h, level, mode};
        do @(posedge clk); while (!s_tready);
        r = apply_op(mode, level, h);
        pending.push_back(known ? typed : r);
    endtask

    task automatic send_op(logic [2:0] mode, logic [4:0] level, logic [9:0] h);
        alloc_result_t none;
        none = '{res: '0, cnt: '0, pk: '0, st: ST_OK};
        send_word(mode, level, h, 1'b0, none);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
    endtask

    // result side: random stall, compare on handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending.size() == 0)
                begin
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                    errors++;
                end
                else
                begin
                    alloc_result_t e;
                    e = pending.pop_front();
                    if (m_tdata[9:0] !== e.res)
                    begin
                        $display("%0t: result_handle exp %0d got %0d", $time, e.res,
                                 m_tdata[9:0]);
                        errors++;
                    end
                    if (m_tdata[19:10] !== e.cnt)
                    begin
                        $display("%0t: count exp %0d got %0d", $time, e.cnt,
                                 m_tdata[19:10]);
                        errors++;
                    end
                    if (m_tdata[29:20] !== e.pk)
                    begin
                        $display("%0t: peak_handle exp %0d got %0d", $time, e.pk,
                                 m_tdata[29:20]);
                        errors++;
                    end
                    if (m_tdata[31:30] !== e.st)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, e.st,
                                 m_tdata[31:30]);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    stim_row_t dir_rows[] = '{
        '{MODE_ALLOC,  5'd1,  10'd0,    1, 10'd1, 10'd0, 10'd1, ST_OK},
        '{MODE_ALLOC,  5'd16, 10'd0,    1, 10'd1, 10'd0, 10'd1, ST_OK},
        '{MODE_ALLOC,  5'd0,  10'd0,    1, 10'd0, 10'd0, 10'd0, ST_OK},
        '{MODE_CHECK,  5'd17, 10'd1,    1, 10'd0, 10'd0, 10'd0, ST_OK},
        '{MODE_MARK,   5'd31, 10'd1023, 1, 10'd0, 10'd0, 10'd0, ST_OK},
        '{MODE_NONE,   5'd1,  10'd1,    1, 10'd0, 10'd0, 10'd1, ST_OK},
        '{MODE_MARK,   5'd1,  10'd1023, 1, 10'd0, 10'd0, 10'd1, ST_RANGE},
        '{MODE_REUSE,  5'd1,  10'd2,    1, 10'd0, 10'd0, 10'd1, ST_RANGE},
        '{MODE_CHECK,  5'd1,  10'd2,    1, 10'd0, 10'd0, 10'd1, ST_RANGE},
        '{MODE_CHECK,  5'd1,  10'd1,    1, 10'd0, 10'd0, 10'd1, ST_OK},
        '{MODE_MARK,   5'd1,  10'd0,    1, 10'd0, 10'd0, 10'd1, ST_OK},
        '{MODE_MARK,   5'd1,  10'd1,    1, 10'd0, 10'd0, 10'd1, ST_OK},
        '{MODE_COUNT,  5'd1,  10'd0,    1, 10'd0, 10'd1, 10'd1, ST_OK},
        '{MODE_ALLOC,  5'd1,  10'd0,    1, 10'd2, 10'd0, 10'd2, ST_OK},
        '{MODE_REUSE,  5'd1,  10'd2,    0, '0, '0, '0, '0},
        '{MODE_ALLOC,  5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_REUSE,  5'd1,  10'd1,    0, '0, '0, '0, '0},
        '{MODE_REUSE,  5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_ALLOC,  5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_ALLOC,  5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_MARK,   5'd1,  10'd3,    0, '0, '0, '0, '0},
        '{MODE_SWEEP,  5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_ALLOC,  5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_UNMARK, 5'd1,  10'd0,    0, '0, '0, '0, '0},
        '{MODE_COUNT,  5'd1,  10'd0,    0, '0, '0, '0, '0}
    };

    task automatic random_word();
        int unsigned pick;
        logic [2:0]  mode;
        logic [4:0]  level;
        logic [9:0]  h;
        pick = $urandom_range(99);
        if (pick < 36)      mode = MODE_ALLOC;
        else if (pick < 56) mode = MODE_MARK;
        else if (pick < 64) mode = MODE_REUSE;
        else if (pick < 70) mode = MODE_SWEEP;
        else if (pick < 74) mode = MODE_UNMARK;
        else if (pick < 81) mode = MODE_COUNT;
        else if (pick < 97) mode = MODE_CHECK;
        else                mode = MODE_NONE;
        // most traffic on a few levels so state builds up
        pick = $urandom_range(99);
        if (pick < 80)      level = 5'($urandom_range(4, 1));
        else if (pick < 96) level = 5'($urandom_range(NLEV, 1));
        else                level = 5'($urandom_range(31));
        if (level >= 1 && level <= NLEV && $urandom_range(99) < 75)
            h = 10'($urandom_range(first_unused[level-1] - 1));
        else
            h = 10'($urandom_range(1023));
        send_op(mode, level, h);
    endtask

    initial
    begin
        alloc_result_t typed;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        rst_n        = 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        for (int l = 0; l < NLEV; l++)
        begin
            first_unused[l] = 1;
            free_head[l]    = 0;
            free_count[l]   = CAP - 1;
            reuse_slot[l]   = 0;
            peak[l]         = 0;
            for (int i = 0; i < CAP; i++)
            begin
                mark_bits[l][i] = 0;
                next_link[l][i] = 0;
            end
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            typed = '{res: dir_rows[i].res, cnt: dir_rows[i].cnt,
                      pk: dir_rows[i].pk, st: dir_rows[i].st};
            send_word(dir_rows[i].mode, dir_rows[i].level, dir_rows[i].handle,
                      dir_rows[i].known, typed);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 78; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 78; end
                3: begin idle_pct = 10; stall_pct = 10; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < NRAND / 5; n++) random_word();
        end

        // sender holds off until everything is back, then a short burst
        wait_drained();
        idle_pct  = 0;
        stall_pct = 10;
        send_op(MODE_ALLOC, NLEV, 10'd0);
        send_op(MODE_MARK, NLEV, 10'd1023);
        send_op(MODE_COUNT, NLEV, 10'd0);
        send_op(MODE_SWEEP, NLEV, 10'd0);
        send_op(MODE_ALLOC, NLEV, 10'd0);
        send_op(MODE_ALLOC, NLEV, 10'd0);

        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0 && pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### mark_sweep_handle_allocator.f
src/msha_pkg.sv
src/msha_datapath.sv
src/msha_ctrl.sv
src/mark_sweep_handle_allocator.sv
tb/mark_sweep_handle_allocator_tb.sv
